// ===== src/ksat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the keyed sum aggregation table.
// Used by ksat_store, ksat_ctrl and keyed_sum_aggregation_table_unit; depends on nothing.
package ksat_pkg;

    // Default sizes of the table
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 64;

    // Fixed field widths of the item and result
    localparam int KEY_W  = 64;
    localparam int SEV_W  = 8;
    localparam int SUM_W  = 32;
    localparam int KIND_W = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Operation codes of an input item
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    // One input item
    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [SEV_W-1:0] severity;
    } req_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  entry_key;
        logic [SUM_W-1:0]  total;
        logic              last;
    } rsp_t;

    // Control from the sequencer to the table memories
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic sum_we;
    } store_ctl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DUMP
    } state_t;

endpackage

// ===== src/ksat_store.sv =====
`timescale 1ns / 1ps
// Key and sum memories of the aggregation table, one read and one write port each.
// Depends on ksat_pkg for the control struct and field widths.
module ksat_store #(
    parameter int TABLE_ENTRIES = ksat_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = ksat_pkg::KEY_BITS_DEF,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  logic                       clk,
    input  ksat_pkg::store_ctl_t       ctl,
    input  logic [AW-1:0]              rd_addr,
    input  logic [AW-1:0]              wr_addr,
    input  logic [KEY_BITS-1:0]        wr_key,
    input  logic [ksat_pkg::SUM_W-1:0] wr_sum,
    output logic [KEY_BITS-1:0]        rd_key,
    output logic [ksat_pkg::SUM_W-1:0] rd_sum
);
    import ksat_pkg::*;

    logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
    logic [SUM_W-1:0]    sum_mem [TABLE_ENTRIES];
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [SUM_W-1:0]    rd_sum_reg;

    // Key memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    // Sum memory: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.sum_we)
        begin
            sum_mem[wr_addr] <= wr_sum;
        end
        if (ctl.rd_en)
        begin
            rd_sum_reg <= sum_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_sum = rd_sum_reg;

endmodule

// ===== src/ksat_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the aggregation table: linear key search, update, append and dump.
// Depends on ksat_pkg; drives the memories in ksat_store.
module ksat_ctrl #(
    parameter int TABLE_ENTRIES = ksat_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = ksat_pkg::KEY_BITS_DEF,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ksat_pkg::req_t             item,
    output ksat_pkg::rsp_t             result,
    output logic                       result_strobe,
    output ksat_pkg::store_ctl_t       ctl,
    output logic [AW-1:0]              rd_addr,
    output logic [AW-1:0]              wr_addr,
    output logic [KEY_BITS-1:0]        wr_key,
    output logic [ksat_pkg::SUM_W-1:0] wr_sum,
    input  logic [KEY_BITS-1:0]        rd_key,
    input  logic [ksat_pkg::SUM_W-1:0] rd_sum
);
    import ksat_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_ENTRIES);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SEV_W-1:0]    sev_reg, sev_next;
    rsp_t                rsp_reg, rsp_next;
    logic                strobe_reg, strobe_next;

    logic                last_idx;
    logic [AW-1:0]       follow_idx;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;

    // Position in the scan and the saturated update of the entry under compare.
    assign last_idx   = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign follow_idx = last_idx ? '0 : idx_reg + AW'(1);
    assign sum_wide   = {1'b0, rd_sum} + (SUM_W + 1)'(sev_reg);
    assign sum_sat    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        sev_reg <= sev_next;
        rsp_reg <= rsp_next;
    end

    // Next state, memory control and result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        sev_next    = sev_reg;
        rsp_next    = rsp_reg;
        strobe_next = 1'b0;
        ctl         = '0;
        rd_addr     = '0;
        wr_addr     = count_reg[AW-1:0];
        wr_key      = key_reg;
        wr_sum      = SUM_W'(sev_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = item.key[KEY_BITS-1:0];
                    sev_next   = item.severity;
                    idx_next   = '0;
                    ctl.rd_en  = 1'b1;
                    if (item.operation == OP_ADD)
                    begin
                        if (count_reg == '0)
                        begin
                            // Empty table: the first key goes straight in.
                            wr_key     = item.key[KEY_BITS-1:0];
                            wr_sum     = SUM_W'(item.severity);
                            ctl.key_we = 1'b1;
                            ctl.sum_we = 1'b1;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.kind      = KIND_EMPTY;
                            rsp_next.entry_key = '0;
                            rsp_next.total     = '0;
                            rsp_next.last      = 1'b1;
                            strobe_next        = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DUMP;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // Compare the entry read last cycle while the next one is read.
                rd_addr   = follow_idx;
                ctl.rd_en = 1'b1;
                if (rd_key == key_reg)
                begin
                    wr_addr    = idx_reg;
                    wr_sum     = sum_sat;
                    ctl.sum_we = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (last_idx)
                begin
                    if (count_reg == COUNT_FULL)
                    begin
                        rsp_next.kind      = KIND_FULL;
                        rsp_next.entry_key = KEY_W'(key_reg);
                        rsp_next.total     = '0;
                        rsp_next.last      = 1'b1;
                        strobe_next        = 1'b1;
                    end
                    else
                    begin
                        ctl.key_we = 1'b1;
                        ctl.sum_we = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = follow_idx;
                end
            end

            ST_DUMP:
            begin
                // One entry per cycle in insertion order, then the table is emptied.
                rd_addr            = follow_idx;
                ctl.rd_en          = 1'b1;
                rsp_next.kind      = KIND_ENTRY;
                rsp_next.entry_key = KEY_W'(rd_key);
                rsp_next.total     = rd_sum;
                rsp_next.last      = last_idx;
                strobe_next        = 1'b1;
                idx_next           = follow_idx;
                if (last_idx)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = rsp_reg;
    assign result_strobe = strobe_reg;

    // The entry count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= COUNT_FULL)
        else $error("entry count above table size");

    // A search or dump only walks over stored entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_DUMP) |-> CW'(idx_reg) < count_reg)
        else $error("scan index beyond stored entries");

    // A table-full error is only reported when every entry is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.kind == KIND_FULL) |-> count_reg == COUNT_FULL)
        else $error("table-full error with room left");

    // The final dumped entry coincides with an emptied table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.kind == KIND_ENTRY && rsp_reg.last) |-> count_reg == '0)
        else $error("table not cleared after dump");

    // Adds never produce entry results, so a dump result needs the dump state in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.kind == KIND_ENTRY) |-> $past(state_reg) == ST_DUMP)
        else $error("entry result outside a dump");

endmodule

// ===== src/keyed_sum_aggregation_table_unit.sv =====
`timescale 1ns / 1ps
// An add on an empty table writes at once and never raises busy; else busy covers a search
// that stops at the hit entry or, on a miss, after the last stored entry; the key compare
// walks one memory read per cycle. A dump is busy while it reads out every entry; results
// pass the memory read and result registers, one per cycle. An empty-table dump shows its
// result in the cycle after start, a table-full error in the cycle after the search ends.
// Results never stall. Reset clears the entry count and sequencer; memories keep content.
module keyed_sum_aggregation_table_unit #(
    parameter int TABLE_ENTRIES = ksat_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = ksat_pkg::KEY_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ksat_pkg::req_t item,
    output ksat_pkg::rsp_t result,
    output logic           result_strobe
);
    import ksat_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    store_ctl_t          ctl;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_key;
    logic [SUM_W-1:0]    wr_sum;
    logic [KEY_BITS-1:0] rd_key;
    logic [SUM_W-1:0]    rd_sum;

    // Sequencer for search, update, append and dump.
    ksat_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .AW            (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe),
        .ctl           (ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_key        (wr_key),
        .wr_sum        (wr_sum),
        .rd_key        (rd_key),
        .rd_sum        (rd_sum)
    );

    // Key and sum memories.
    ksat_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .AW            (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_sum  (wr_sum),
        .rd_key  (rd_key),
        .rd_sum  (rd_sum)
    );

endmodule
